// File: hdl/bmh_pkg.sv
// shared constants for the binary min-heap delete-min block
package bmh_pkg;

    // item field widths and default heap capacity
    localparam int DATA_W       = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: hdl/binary_min_heap_delete_min.sv
// Binary min-heap with load, delete-minimum with sift-down, and order check.
//
// The input channel (i_in_valid / o_in_stall) carries one item: a kind and a
// value. Load appends the value at the next free slot; delete removes the root
// and sifts the last element down from the root; check walks every child and
// compares it against its parent. Each item gives exactly one result item on
// the output channel (o_out_valid / i_out_stall): removed minimum, count,
// status and heap order flag.
// The heap lives in one synchronous memory with two read ports and one write
// port, read data arriving in the cycle after the address. One item is worked
// on at a time; o_in_stall is high from acceptance until the result is moved
// into the output register.
// Load, unused kind and faults go straight to the result; delete reads the root
// and last element, then per level reads both children and compares, stopping
// when the moving value is no larger than the smaller child or has no child;
// check reads each parent and child pair in turn and compares them.
// A result waiting under i_out_stall holds its payload; the next item is
// still taken and worked on, and only its final handoff waits for the slot.
// Synchronous active-low reset empties the heap (count zero) and drops any
// pending result; memory contents need no clearing.
module binary_min_heap_delete_min #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bmh_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [bmh_pkg::DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [bmh_pkg::DATA_W-1:0] o_result_value,
    output logic [CW-1:0]                 o_count,
    output logic [bmh_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_heap_ok
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = bmh_pkg::DATA_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DEL_ENDS = 6'b000010,
        S_SIFT_RD  = 6'b000100,
        S_SIFT_CMP = 6'b001000,
        S_CHK      = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_i, n_i;
    logic [CW:0]                 r_k, n_k;
    logic                        r_pend, n_pend;
    logic signed [DW-1:0]        r_v, n_v;
    logic signed [DW-1:0]        r_res, n_res;
    logic [bmh_pkg::STATUS_W-1:0] r_status, n_status;
    logic                        r_ok, n_ok;
    logic                        r_out_valid, n_out_valid;
    logic signed [DW-1:0]        r_o_res;
    logic [CW-1:0]               r_o_count;
    logic [bmh_pkg::STATUS_W-1:0] r_o_status;
    logic                        r_o_ok;

    // heap store and its ports
    logic signed [DW-1:0]        mem [CAPACITY];
    logic signed [DW-1:0]        r_rd_a, r_rd_b;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa, mem_ra, mem_rb;
    logic signed [DW-1:0]        mem_wd;

    logic                        accept, out_free, out_load;
    logic [CW:0]                 two_i, n_ext;
    logic                        has_left, has_right, pick_right;
    logic signed [DW-1:0]        child_val;
    logic [CW-1:0]               left_pos, child_pos;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_DONE) && out_free;

    // child selection for sift-down
    assign two_i      = {r_i, 1'b0};
    assign n_ext      = {1'b0, r_count};
    assign has_left   = two_i <= n_ext;
    assign has_right  = (two_i + 1'b1) <= n_ext;
    assign left_pos   = two_i[CW-1:0];
    assign pick_right = has_right && (r_rd_b < r_rd_a);
    assign child_val  = pick_right ? r_rd_b : r_rd_a;
    assign child_pos  = pick_right ? (left_pos + 1'b1) : left_pos;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_k         = r_k;
        n_pend      = r_pend;
        n_v         = r_v;
        n_res       = r_res;
        n_status    = r_status;
        n_ok        = r_ok;
        mem_we      = 1'b0;
        mem_wa      = AW'(r_count);
        mem_wd      = i_value;
        mem_ra      = '0;
        mem_rb      = AW'(r_count - 1'b1);
        n_out_valid = out_free ? 1'b0 : r_out_valid;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res    = '0;
                    n_status = bmh_pkg::ST_OK;
                    n_ok     = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_kind)
                        bmh_pkg::KIND_LOAD: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = bmh_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        bmh_pkg::KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_status = bmh_pkg::ST_EMPTY;
                            end else begin
                                // root on port a, last element on port b
                                n_state = S_DEL_ENDS;
                            end
                        end
                        bmh_pkg::KIND_CHECK: begin
                            n_ok    = 1'b1;
                            n_k     = (CW+1)'(2);
                            n_pend  = 1'b0;
                            n_state = S_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DEL_ENDS: begin
                n_res   = r_rd_a;
                n_v     = r_rd_b;
                n_count = r_count - 1'b1;
                n_i     = CW'(1);
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (!has_left) begin
                    // no child: the moving value settles here
                    mem_we  = 1'b1;
                    mem_wa  = AW'(r_i - 1'b1);
                    mem_wd  = r_v;
                    n_state = S_DONE;
                end else begin
                    mem_ra  = AW'(two_i - 1'b1);
                    mem_rb  = AW'(two_i);
                    n_state = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_i - 1'b1);
                if (r_v <= child_val) begin
                    mem_wd  = r_v;
                    n_state = S_DONE;
                end else begin
                    // smaller child moves up, hole moves down
                    mem_wd  = child_val;
                    n_i     = child_pos;
                    n_state = S_SIFT_RD;
                end
            end
            S_CHK: begin
                // compare the pair read in the previous cycle
                if (r_pend && (r_rd_a > r_rd_b)) begin
                    n_ok = 1'b0;
                end
                if (r_k <= n_ext) begin
                    mem_ra = AW'((r_k >> 1) - 1'b1);
                    mem_rb = AW'(r_k - 1'b1);
                    n_pend = 1'b1;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_k      <= n_k;
        r_v      <= n_v;
        r_res    <= n_res;
        r_status <= n_status;
        r_ok     <= n_ok;
        if (out_load) begin
            r_o_res    <= r_res;
            r_o_count  <= r_count;
            r_o_status <= r_status;
            r_o_ok     <= r_ok;
        end
    end

    // heap memory, registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= mem[mem_ra];
        r_rd_b <= mem[mem_rb];
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_o_res;
    assign o_count        = r_o_count;
    assign o_status       = r_o_status;
    assign o_heap_ok      = r_o_ok;

endmodule

// File: hdl/bmh_check.sv
// port-level checks for the binary min-heap block, bound to the top level
module bmh_check #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [bmh_pkg::KIND_W-1:0]    i_kind,
    input logic signed [bmh_pkg::DATA_W-1:0] i_value,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [bmh_pkg::DATA_W-1:0] o_result_value,
    input logic [CW-1:0]                 o_count,
    input logic [bmh_pkg::STATUS_W-1:0]  o_status,
    input logic                          o_heap_ok
);

    // count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= CW'(CAPACITY)))
        else $error("count above capacity");

    // full fault only with a full heap
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bmh_pkg::ST_FULL)) |-> (o_count == CW'(CAPACITY)))
        else $error("full status with room left");

    // empty fault only with an empty heap and no removed value
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bmh_pkg::ST_EMPTY))
            |-> ((o_count == '0) && (o_result_value == '0) && !o_heap_ok))
        else $error("empty status inconsistent");

    // order flag comes only from a check, which removes nothing
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_heap_ok)
            |-> ((o_status == bmh_pkg::ST_OK) && (o_result_value == '0)))
        else $error("heap order flag on a non-check result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_result_value) && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind binary_min_heap_delete_min bmh_check #(.CAPACITY(CAPACITY)) u_bmh_check (.*);

// File: tb/tb_binary_min_heap_delete_min.sv
// testbench for the binary min-heap block: load, delete-minimum and order check items
`timescale 1ns / 1ps

module tb_binary_min_heap_delete_min;

    localparam int CAPACITY   = bmh_pkg::CAPACITY_DEF;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ITEM_GOAL  = 950;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 40;

    localparam logic signed [bmh_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [bmh_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

    // one result item as the block should present it
    typedef struct {
        logic signed [bmh_pkg::DATA_W-1:0] result_value;
        logic [CNT_W-1:0]                  count;
        logic [bmh_pkg::STATUS_W-1:0]      status;
        logic                              heap_ok;
    } t_heap_result;

    // heap predictor plus the queue of results still owed by the block
    class t_heap_scoreboard;
        logic signed [bmh_pkg::DATA_W-1:0] slot [CAPACITY];
        int                                held;
        t_heap_result                      owed [$];
        int                                mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // one-based positions map onto slot[p-1]; children of p are 2p and 2p+1
        function void sift_root_down();
            int                                p;
            int                                c;
            logic signed [bmh_pkg::DATA_W-1:0] t;
            p = 1;
            while (2 * p <= held) begin
                c = 2 * p;
                // smaller child, left wins a tie; a lone left child is still compared
                if (c + 1 <= held && slot[c] < slot[c-1])
                    c = c + 1;
                if (slot[p-1] <= slot[c-1])
                    break;
                t = slot[p-1];
                slot[p-1] = slot[c-1];
                slot[c-1] = t;
                p = c;
            end
        endfunction

        function bit order_holds();
            for (int p = 1; 2 * p <= held; p++) begin
                if (slot[p-1] > slot[2*p-1])
                    return 1'b0;
                if (2 * p + 1 <= held && slot[p-1] > slot[2*p])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // apply an accepted item to the predicted heap and queue its result
        function void note_item(logic [bmh_pkg::KIND_W-1:0] kind,
                                logic signed [bmh_pkg::DATA_W-1:0] value);
            t_heap_result r;
            r.result_value = '0;
            r.status       = bmh_pkg::ST_OK;
            r.heap_ok      = 1'b0;
            case (kind)
                bmh_pkg::KIND_LOAD: begin
                    if (held >= CAPACITY) begin
                        r.status = bmh_pkg::ST_FULL;
                    end else begin
                        slot[held] = value;
                        held++;
                    end
                end
                bmh_pkg::KIND_DELETE: begin
                    if (held == 0) begin
                        r.status = bmh_pkg::ST_EMPTY;
                    end else begin
                        r.result_value = slot[0];
                        slot[0] = slot[held-1];
                        held--;
                        sift_root_down();
                    end
                end
                bmh_pkg::KIND_CHECK: begin
                    r.heap_ok = order_holds();
                end
                default: ;
            endcase
            r.count = CNT_W'(held);
            owed.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        endtask

        // compare one result item field by field against the oldest owed one
        task check_result(logic signed [bmh_pkg::DATA_W-1:0] rv, logic [CNT_W-1:0] cnt,
                          logic [bmh_pkg::STATUS_W-1:0] st, logic ok);
            t_heap_result want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result item with none owed: value %0d count %0d",
                                          rv, cnt));
            end else begin
                want = owed.pop_front();
                if (rv !== want.result_value)
                    report_mismatch($sformatf("result_value got %0d want %0d",
                                              rv, want.result_value));
                if (cnt !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d", cnt, want.count));
                if (st !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", st, want.status));
                if (ok !== want.heap_ok)
                    report_mismatch($sformatf("heap_ok got %0b want %0b", ok, want.heap_ok));
            end
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [bmh_pkg::KIND_W-1:0]        i_kind;
    logic signed [bmh_pkg::DATA_W-1:0] i_value;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic signed [bmh_pkg::DATA_W-1:0] o_result_value;
    logic [CNT_W-1:0]                  o_count;
    logic [bmh_pkg::STATUS_W-1:0]      o_status;
    logic                              o_heap_ok;

    t_heap_scoreboard sb;
    int               items_sent;
    int               idle_cycles;
    bit               burst;
    longint           run_top;

    binary_min_heap_delete_min dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_count        (o_count),
        .o_status       (o_status),
        .o_heap_ok      (o_heap_ok)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // handshake monitor: note accepted items, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_kind, i_value);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_result_value, o_count, o_status, o_heap_ok);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver stalls: free runs, sometimes long, then short or long stalls
    initial begin
        int free_len;
        int stall_len;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 12);
            stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
            repeat (free_len) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            repeat (stall_len) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [bmh_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        if (r < 75)
            return bmh_pkg::DATA_W'($signed($urandom_range(0, 16)) - 8);
        case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // next value of an ascending run, so appended loads keep the heap ordered
    function automatic logic signed [bmh_pkg::DATA_W-1:0] next_ascending();
        longint step;
        step = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1000000)) :
                                              longint'($urandom_range(0, 2));
        run_top = run_top + step;
        if (run_top > longint'(VAL_MAX))
            run_top = longint'(VAL_MAX);
        return bmh_pkg::DATA_W'(run_top);
    endfunction

    // present one item, hold it until accepted, then sometimes idle a while
    task automatic issue(input logic [bmh_pkg::KIND_W-1:0] kind,
                         input logic signed [bmh_pkg::DATA_W-1:0] value);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind     = kind;
        i_value    = value;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        int r;
        int fill;
        sb          = new();
        items_sent  = 0;
        idle_cycles = 0;
        burst       = 1'b0;
        run_top     = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = bmh_pkg::KIND_LOAD;
        i_value     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty heap, extremes, ties, out-of-order loads, full heap
        issue(bmh_pkg::KIND_CHECK, '0);
        issue(bmh_pkg::KIND_DELETE, '0);
        issue(bmh_pkg::KIND_LOAD, VAL_MAX);
        issue(bmh_pkg::KIND_LOAD, VAL_MIN);
        issue(bmh_pkg::KIND_LOAD, 32'sd0);
        issue(bmh_pkg::KIND_LOAD, -32'sd1);
        issue(bmh_pkg::KIND_LOAD, 32'sd1);
        issue(bmh_pkg::KIND_LOAD, 32'sd5);
        issue(bmh_pkg::KIND_LOAD, 32'sd5);
        issue(bmh_pkg::KIND_LOAD, -32'sd7);
        issue(bmh_pkg::KIND_LOAD, 32'sd3);
        issue(bmh_pkg::KIND_LOAD, 32'sd3);
        issue(bmh_pkg::KIND_LOAD, 32'sd100);
        issue(bmh_pkg::KIND_LOAD, -32'sd100);
        issue(bmh_pkg::KIND_LOAD, 32'sd42);
        issue(bmh_pkg::KIND_LOAD, 32'sd42);
        issue(bmh_pkg::KIND_LOAD, 32'sd2);
        issue(bmh_pkg::KIND_LOAD, VAL_MAX - 1);
        issue(bmh_pkg::KIND_LOAD, 32'sd123);
        issue(bmh_pkg::KIND_CHECK, '0);
        issue(bmh_pkg::KIND_DELETE, '0);
        issue(bmh_pkg::KIND_DELETE, '0);
        issue(bmh_pkg::KIND_CHECK, '0);

        // random phases: ordered heaps worked down, and unordered noise
        while (items_sent < ITEM_GOAL) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                // drain, then build an ordered heap from an ascending run
                while (sb.held > 0)
                    issue(bmh_pkg::KIND_DELETE, pick_value());
                run_top = ($urandom_range(0, 1) == 0) ? longint'($signed($urandom))
                                                      : longint'($urandom_range(0, 20)) - 10;
                fill = $urandom_range(1, CAPACITY);
                repeat (fill) issue(bmh_pkg::KIND_LOAD, next_ascending());
                repeat ($urandom_range(8, 30)) begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        issue(bmh_pkg::KIND_DELETE, pick_value());
                    else if (r < 8)
                        issue(bmh_pkg::KIND_CHECK, pick_value());
                    else
                        issue(bmh_pkg::KIND_LOAD, next_ascending());
                end
            end else begin
                // loose mix of kinds with arbitrary values
                repeat ($urandom_range(10, 40)) begin
                    r = $urandom_range(0, 99);
                    if (r < 45 || (sb.held == 0 && r < 80))
                        issue(bmh_pkg::KIND_LOAD, pick_value());
                    else if (r < 85)
                        issue(bmh_pkg::KIND_DELETE, pick_value());
                    else
                        issue(bmh_pkg::KIND_CHECK, pick_value());
                end
            end
        end

        // wait for every owed result, then a quiet stretch
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
